[src/raster_blit_fill_engine_defines.svh]
// Assertion macros shared by the raster blit and fill engine.
`ifndef RASTER_BLIT_FILL_ENGINE_DEFINES_SVH
`define RASTER_BLIT_FILL_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define RBFE_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define RBFE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/rbfe_pkg.sv]
// Types, codes and helper functions of the raster blit and fill engine.
`default_nettype none

package rbfe_pkg;

    localparam int HRES_PIXELS_DEF = 64;
    localparam int STORE_BYTES_DEF = 16384;

    // Command codes.
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_FILL = 2'd2;
    localparam logic [1:0] CMD_BLIT = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PIXEL_MODE = 2'd0;
    localparam logic [1:0] CFG_RASTER_OP  = 2'd1;
    localparam logic [1:0] CFG_PLANE_MASK = 2'd2;

    // Pixel modes; any other code strides one byte per pixel.
    localparam logic [1:0] PM_2BYTE = 2'd1;
    localparam logic [1:0] PM_4BYTE = 2'd2;

    localparam logic       ROP_XOR          = 1'b1;
    localparam logic [7:0] PLANE_MASK_RESET = 8'hFF;

    typedef struct packed {
        logic [1:0] pixel_mode;
        logic       raster_op;
        logic [7:0] plane_mask;
    } t_cfg;

    // Combines destination byte d with source byte s under the plane mask.
    function automatic logic [7:0] apply_op(input t_cfg cfg, input logic [7:0] d,
                                            input logic [7:0] s);
        logic [7:0] res;
        if (cfg.raster_op == ROP_XOR) begin
            res = d ^ (s & cfg.plane_mask);
        end else begin
            res = (s & cfg.plane_mask) | (d & ~cfg.plane_mask);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[src/raster_blit_fill_engine.sv]
// Raster blit and fill engine: frame store, command sequencer and shared address unit.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+--------------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_cmd, src/dst position, size, data
//  out     | output    | o_out_valid / i_out_ready  | o_read_data, o_done_kind
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// Load and read first bring mem_addr into the store by subtracting STORE_BYTES, then access it.
// Fill and blit first step the base addresses to the start lines, where a bottom-up walk starts
// at the bottom line, then walk the rectangle with one read port and one shared adder.
// Reset is synchronous and active low; the store is not cleared.
// A result waits in the output register while the next transaction runs; a second result
// holds the engine in its final state until the first one has been taken.
`default_nettype none

module raster_blit_fill_engine #(
    parameter int HRES_PIXELS = rbfe_pkg::HRES_PIXELS_DEF,
    parameter int STORE_BYTES = rbfe_pkg::STORE_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [7:0]  i_src_x,
    input  wire logic [5:0]  i_src_y,
    input  wire logic [7:0]  i_dst_x,
    input  wire logic [5:0]  i_dst_y,
    input  wire logic [8:0]  i_rect_width,
    input  wire logic [6:0]  i_rect_height,
    input  wire logic [7:0]  i_fill_color,
    input  wire logic [13:0] i_mem_addr,
    input  wire logic [7:0]  i_mem_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_read_data,
    output logic [1:0]       o_done_kind,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

`include "raster_blit_fill_engine_defines.svh"

    localparam int AW = $clog2(STORE_BYTES);
    localparam int UW = AW + 1;
    localparam int CW = (AW + 1 > 14) ? AW + 1 : 14;

    localparam int STR0 = HRES_PIXELS % STORE_BYTES;
    localparam int STR1 = (HRES_PIXELS * 2) % STORE_BYTES;
    localparam int STR2 = (HRES_PIXELS * 4) % STORE_BYTES;

    localparam logic [AW-1:0] STRIDE0 = STR0[AW-1:0];
    localparam logic [AW-1:0] STRIDE1 = STR1[AW-1:0];
    localparam logic [AW-1:0] STRIDE2 = STR2[AW-1:0];
    localparam logic [UW:0]   SIZE_U  = STORE_BYTES[UW:0];
    localparam logic [CW-1:0] SIZE_C  = STORE_BYTES[CW-1:0];

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RED   = 4'd1;
    localparam logic [3:0] ST_MEM   = 4'd2;
    localparam logic [3:0] ST_SB    = 4'd3;
    localparam logic [3:0] ST_DB    = 4'd4;
    localparam logic [3:0] ST_WM1   = 4'd5;
    localparam logic [3:0] ST_OFFS  = 4'd6;
    localparam logic [3:0] ST_OFFD  = 4'd7;
    localparam logic [3:0] ST_ROWSA = 4'd8;
    localparam logic [3:0] ST_ROWDA = 4'd9;
    localparam logic [3:0] ST_RDS   = 4'd10;
    localparam logic [3:0] ST_RDD   = 4'd11;
    localparam logic [3:0] ST_WR    = 4'd12;
    localparam logic [3:0] ST_RSB   = 4'd13;
    localparam logic [3:0] ST_RDB   = 4'd14;
    localparam logic [3:0] ST_DONE  = 4'd15;

    logic [3:0]      r_state, n_state;
    logic [1:0]      r_cmd, n_cmd;
    logic [CW-1:0]   r_ma, n_ma;
    logic [7:0]      r_mdata, n_mdata;
    logic [8:0]      r_w, n_w;
    logic [6:0]      r_h, n_h;
    logic [8:0]      r_col, n_col;
    logic [6:0]      r_row, n_row;
    logic [7:0]      r_cnt, n_cnt;
    logic [7:0]      r_yd0, n_yd0;
    logic [7:0]      r_xs, n_xs;
    logic [7:0]      r_xd, n_xd;
    logic            r_up, n_up;
    logic            r_rtl, n_rtl;
    logic [AW-1:0]   r_sb, n_sb;
    logic [AW-1:0]   r_db, n_db;
    logic [AW-1:0]   r_sa, n_sa;
    logic [AW-1:0]   r_da, n_da;
    logic [AW-1:0]   r_wa, n_wa;
    logic [AW-1:0]   r_wm1, n_wm1;
    logic [AW-1:0]   r_offs, n_offs;
    logic [AW-1:0]   r_offd, n_offd;
    logic [7:0]      r_src, n_src;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_data, n_out_data;
    logic [1:0]      r_out_kind, n_out_kind;
    rbfe_pkg::t_cfg  r_cfg, n_cfg;

    logic [7:0]      r_mem [STORE_BYTES];
    logic [7:0]      r_rd_data;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_waddr, mem_raddr;
    logic [7:0]      mem_wdata;

    logic [AW-1:0]   stride;
    logic [UW-1:0]   u_a, u_b;
    logic            u_sub;
    logic [UW:0]     u_sum, u_dif, u_fix;
    logic [AW-1:0]   u_res;

    logic            accept;
    logic            up_in, rtl_in;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_done_kind = r_out_kind;

    always_comb begin
        unique case (r_cfg.pixel_mode)
            rbfe_pkg::PM_2BYTE: stride = STRIDE1;
            rbfe_pkg::PM_4BYTE: stride = STRIDE2;
            default:            stride = STRIDE0;
        endcase
    end

    // Operand select for the shared modular adder. Every operand pair keeps the sum
    // below twice the store size, so one correction step brings it back into range.
    always_comb begin
        u_a   = '0;
        u_b   = '0;
        u_sub = 1'b0;
        unique case (r_state)
            ST_SB: begin
                u_a = UW'(r_sb);
                u_b = UW'(stride);
            end
            ST_DB: begin
                u_a = UW'(r_db);
                u_b = UW'(stride);
            end
            ST_WM1: begin
                u_a = UW'(r_w - 9'd1);
            end
            ST_OFFS: begin
                u_a = UW'(r_xs);
                u_b = UW'(r_wm1);
            end
            ST_OFFD: begin
                u_a = UW'(r_xd);
                u_b = UW'(r_wm1);
            end
            ST_ROWSA: begin
                u_a = UW'(r_sb);
                u_b = UW'(r_offs);
            end
            ST_ROWDA: begin
                u_a = UW'(r_db);
                u_b = UW'(r_offd);
            end
            ST_RDS: begin
                u_a   = UW'(r_sa);
                u_b   = UW'(1);
                u_sub = r_rtl;
            end
            ST_RDD: begin
                u_a   = UW'(r_da);
                u_b   = UW'(1);
                u_sub = r_rtl;
            end
            ST_RSB: begin
                u_a   = UW'(r_sb);
                u_b   = UW'(stride);
                u_sub = r_up;
            end
            ST_RDB: begin
                u_a   = UW'(r_db);
                u_b   = UW'(stride);
                u_sub = r_up;
            end
            default: begin
                u_sub = 1'b0;
            end
        endcase
    end

    always_comb begin
        u_sum = {1'b0, u_a} + {1'b0, u_b};
        u_dif = {1'b0, u_a} - {1'b0, u_b};
        if (u_sub) begin
            u_fix = u_dif[UW] ? (u_dif + SIZE_U) : u_dif;
        end else begin
            u_fix = (u_sum >= SIZE_U) ? (u_sum - SIZE_U) : u_sum;
        end
        u_res = u_fix[AW-1:0];
    end

    assign up_in  = (i_cmd == rbfe_pkg::CMD_BLIT) && (i_src_y < i_dst_y);
    assign rtl_in = (i_cmd == rbfe_pkg::CMD_BLIT) && (i_src_y == i_dst_y) &&
                    (i_src_x < i_dst_x);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_ma        = r_ma;
        n_mdata     = r_mdata;
        n_w         = r_w;
        n_h         = r_h;
        n_col       = r_col;
        n_row       = r_row;
        n_cnt       = r_cnt;
        n_yd0       = r_yd0;
        n_xs        = r_xs;
        n_xd        = r_xd;
        n_up        = r_up;
        n_rtl       = r_rtl;
        n_sb        = r_sb;
        n_db        = r_db;
        n_sa        = r_sa;
        n_da        = r_da;
        n_wa        = r_wa;
        n_wm1       = r_wm1;
        n_offs      = r_offs;
        n_offd      = r_offd;
        n_src       = r_src;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        n_out_kind  = r_out_kind;
        n_cfg       = r_cfg;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_wa;
        mem_raddr   = r_sa;
        mem_wdata   = rbfe_pkg::apply_op(r_cfg, r_rd_data, r_src);

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbfe_pkg::CFG_PIXEL_MODE: n_cfg.pixel_mode = i_cfg_data[1:0];
                rbfe_pkg::CFG_RASTER_OP:  n_cfg.raster_op  = i_cfg_data[0];
                rbfe_pkg::CFG_PLANE_MASK: n_cfg.plane_mask = i_cfg_data;
                default:                  n_cfg            = r_cfg;
            endcase
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd;
                    n_ma    = CW'(i_mem_addr);
                    n_mdata = i_mem_data;
                    n_w     = i_rect_width;
                    n_h     = i_rect_height;
                    n_xs    = i_src_x;
                    n_xd    = i_dst_x;
                    n_up    = up_in;
                    n_rtl   = rtl_in;
                    n_sb    = '0;
                    n_db    = '0;
                    n_col   = '0;
                    n_row   = '0;
                    n_src   = i_fill_color;
                    // Start lines: the bottom line of each rectangle for a bottom-up walk.
                    if (i_cmd == rbfe_pkg::CMD_FILL) begin
                        n_cnt = '0;
                        n_yd0 = 8'(i_dst_y);
                    end else if (up_in) begin
                        n_cnt = 8'(i_src_y) + 8'(i_rect_height) - 8'd1;
                        n_yd0 = 8'(i_dst_y) + 8'(i_rect_height) - 8'd1;
                    end else begin
                        n_cnt = 8'(i_src_y);
                        n_yd0 = 8'(i_dst_y);
                    end
                    if ((i_cmd == rbfe_pkg::CMD_LOAD) || (i_cmd == rbfe_pkg::CMD_READ)) begin
                        n_state = ST_RED;
                    end else if ((i_rect_width == '0) || (i_rect_height == '0)) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SB;
                    end
                end
            end
            ST_RED: begin
                if (r_ma >= SIZE_C) begin
                    n_ma = r_ma - SIZE_C;
                end else begin
                    n_state = ST_MEM;
                end
            end
            ST_MEM: begin
                mem_raddr = r_ma[AW-1:0];
                mem_waddr = r_ma[AW-1:0];
                mem_wdata = r_mdata;
                mem_re    = (r_cmd == rbfe_pkg::CMD_READ);
                mem_we    = (r_cmd == rbfe_pkg::CMD_LOAD);
                n_state   = ST_DONE;
            end
            ST_SB: begin
                if (r_cnt == '0) begin
                    n_cnt   = r_yd0;
                    n_state = ST_DB;
                end else begin
                    n_sb  = u_res;
                    n_cnt = r_cnt - 8'd1;
                end
            end
            ST_DB: begin
                if (r_cnt == '0) begin
                    n_state = ST_WM1;
                end else begin
                    n_db  = u_res;
                    n_cnt = r_cnt - 8'd1;
                end
            end
            ST_WM1: begin
                n_wm1   = r_rtl ? u_res : '0;
                n_state = ST_OFFS;
            end
            ST_OFFS: begin
                n_offs  = u_res;
                n_state = ST_OFFD;
            end
            ST_OFFD: begin
                n_offd  = u_res;
                n_state = ST_ROWSA;
            end
            ST_ROWSA: begin
                n_sa    = u_res;
                n_state = ST_ROWDA;
            end
            ST_ROWDA: begin
                n_da    = u_res;
                n_state = (r_cmd == rbfe_pkg::CMD_BLIT) ? ST_RDS : ST_RDD;
            end
            ST_RDS: begin
                mem_re    = 1'b1;
                mem_raddr = r_sa;
                n_sa      = u_res;
                n_state   = ST_RDD;
            end
            ST_RDD: begin
                mem_re    = 1'b1;
                mem_raddr = r_da;
                n_da      = u_res;
                n_wa      = r_da;
                // For a blit the source byte read in the previous cycle is now available.
                if (r_cmd == rbfe_pkg::CMD_BLIT) begin
                    n_src = r_rd_data;
                end
                n_state = ST_WR;
            end
            ST_WR: begin
                mem_we = 1'b1;
                if (r_col == r_w - 9'd1) begin
                    n_col = '0;
                    if (r_row == r_h - 7'd1) begin
                        n_state = ST_DONE;
                    end else begin
                        n_row   = r_row + 7'd1;
                        n_state = ST_RSB;
                    end
                end else begin
                    n_col   = r_col + 9'd1;
                    n_state = (r_cmd == rbfe_pkg::CMD_BLIT) ? ST_RDS : ST_RDD;
                end
            end
            ST_RSB: begin
                n_sb    = u_res;
                n_state = ST_RDB;
            end
            ST_RDB: begin
                n_db    = u_res;
                n_state = ST_ROWSA;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_cmd;
                    n_out_data  = (r_cmd == rbfe_pkg::CMD_READ) ? r_rd_data : 8'd0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ST_IDLE;
            r_out_valid      <= 1'b0;
            r_cfg.pixel_mode <= '0;
            r_cfg.raster_op  <= 1'b0;
            r_cfg.plane_mask <= rbfe_pkg::PLANE_MASK_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
        r_cmd      <= n_cmd;
        r_ma       <= n_ma;
        r_mdata    <= n_mdata;
        r_w        <= n_w;
        r_h        <= n_h;
        r_col      <= n_col;
        r_row      <= n_row;
        r_cnt      <= n_cnt;
        r_yd0      <= n_yd0;
        r_xs       <= n_xs;
        r_xd       <= n_xd;
        r_up       <= n_up;
        r_rtl      <= n_rtl;
        r_sb       <= n_sb;
        r_db       <= n_db;
        r_sa       <= n_sa;
        r_da       <= n_da;
        r_wa       <= n_wa;
        r_wm1      <= n_wm1;
        r_offs     <= n_offs;
        r_offd     <= n_offd;
        r_src      <= n_src;
        r_out_data <= n_out_data;
        r_out_kind <= n_out_kind;
    end

    // Frame store: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    `RBFE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, !o_in_ready,
                      "engine still ready after taking a transaction")
    `RBFE_ASSERT_IMPL(a_walk_in_range, i_clk, i_rst_n, r_state == ST_WR,
                      (r_col < r_w) && (r_row < r_h),
                      "rectangle walk counter outside the rectangle")
    `RBFE_ASSERT_IMPL(a_unit_wrapped, i_clk, i_rst_n, r_state != ST_IDLE,
                      {2'b00, u_res} < SIZE_U,
                      "address unit result not reduced modulo store size")
    `RBFE_ASSERT_NEXT(a_result_handoff, i_clk, i_rst_n,
                      (r_state == ST_DONE) && (!o_out_valid || i_out_ready),
                      o_out_valid && o_in_ready,
                      "finished command did not reach the output register")

endmodule

`default_nettype wire
